>>> rtl/qrca_pkg.sv
package qrca_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int VW = COORD_WIDTH + 4;
    localparam int MW = VW;
    localparam int PW = 2 * MW;
    localparam int ACCW = PW + 8;
    localparam int AREA_WIDTH = 63;
    localparam int MAX_POLY_VERTICES = 9;
    localparam int POLY_CAP = 2 * MAX_POLY_VERTICES + 1;
    localparam int IW = $clog2(POLY_CAP + 1);
    localparam int MUL_CNT_W = $clog2(MW + 1);
    localparam int DIV_CNT_W = $clog2(PW + 1);

    typedef logic signed [VW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_RIGHT,
        EDGE_BOTTOM,
        EDGE_TOP
    } clip_edge_t;

    typedef struct packed {
        logic          shift;
        logic          wr_en;
        logic [IW-1:0] wr_idx;
        vertex_t       wr_data;
    } cell_ctrl_t;

endpackage

>>> rtl/qrca_cell.sv
module qrca_cell
    import qrca_pkg::*;
(
    input  logic          clk,
    input  cell_ctrl_t    ctrl,
    input  logic [IW-1:0] position,
    input  vertex_t       neighbor,
    output vertex_t       vertex
);

    vertex_t vertex_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && ctrl.wr_idx == position)
        begin
            vertex_reg <= ctrl.wr_data;
        end
        else if (ctrl.shift)
        begin
            vertex_reg <= neighbor;
        end
    end

    assign vertex = vertex_reg;

endmodule

>>> rtl/qrca_mul.sv
module qrca_mul
    import qrca_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] op_a,
    input  logic [MW-1:0] op_b,
    output logic          done,
    output logic [PW-1:0] product
);

    logic [PW-1:0]        acc_reg;
    logic [PW-1:0]        mcand_reg;
    logic [MW-1:0]        mplier_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= MUL_CNT_W'(MW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {{(PW-MW){1'b0}}, op_a};
            mplier_reg <= op_b;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/qrca_div.sv
module qrca_div
    import qrca_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [PW-1:0] dividend,
    input  logic [MW-1:0] divisor,
    output logic          done,
    output logic [PW-1:0] quotient,
    output logic [MW-1:0] remainder
);

    logic [PW-1:0]        dq_reg;
    logic [MW-1:0]        rem_reg;
    logic [MW-1:0]        dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [MW:0]          trial;
    logic                 qbit;

    assign trial = {rem_reg, dq_reg[PW-1]};
    assign qbit  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_CNT_W'(PW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            dq_reg  <= {dq_reg[PW-2:0], qbit};
            rem_reg <= qbit ? MW'(trial - {1'b0, dvs_reg}) : trial[MW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/quad_rect_clip_overlap_area_top.sv
// Channel   Direction  Handshake             Payload
// item      in         start high, busy low  cell_center_x/y, cell_width/height, corner0..3_x/y
// result    out        done, one cycle       overlap_area
//
// For each item the four corners are loaded, then the polygon is clipped against each cell edge in
// turn; a polygon edge that crosses the clip boundary gets its intersection from a serial multiply
// of 36-bit magnitudes followed by a serial divide of the 72-bit product, and each remaining vertex
// then adds two products to the area sum. The bit-serial multiplier serves both; the divider is not shared.
// Reset is asynchronous and clears the sequencer and the multiplier and divider control only;
// busy is low after reset.
// The receiver cannot stall: overlap_area is updated in the cycle in which done is high and holds until the next done.
module quad_rect_clip_overlap_area_top
    import qrca_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic signed [COORD_WIDTH-1:0] cell_center_x,
    input  logic signed [COORD_WIDTH-1:0] cell_center_y,
    input  logic [COORD_WIDTH-2:0]        cell_width,
    input  logic [COORD_WIDTH-2:0]        cell_height,
    input  logic signed [COORD_WIDTH-1:0] corner0_x,
    input  logic signed [COORD_WIDTH-1:0] corner0_y,
    input  logic signed [COORD_WIDTH-1:0] corner1_x,
    input  logic signed [COORD_WIDTH-1:0] corner1_y,
    input  logic signed [COORD_WIDTH-1:0] corner2_x,
    input  logic signed [COORD_WIDTH-1:0] corner2_y,
    input  logic signed [COORD_WIDTH-1:0] corner3_x,
    input  logic signed [COORD_WIDTH-1:0] corner3_y,
    output logic [AREA_WIDTH-1:0]         overlap_area
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PASS,
        ST_STEP,
        ST_ISECT_MUL,
        ST_ISECT_DIV,
        ST_POP,
        ST_AREA_START,
        ST_AREA_STEP,
        ST_AREA_MUL1,
        ST_AREA_MUL2,
        ST_FINISH
    } state_t;

    function automatic coord_t ext_coord(logic signed [COORD_WIDTH-1:0] v);
        ext_coord = {{(VW-COORD_WIDTH-1){v[COORD_WIDTH-1]}}, v, 1'b0};
    endfunction

    function automatic coord_t ext_size(logic [COORD_WIDTH-2:0] v);
        ext_size = {{(VW-COORD_WIDTH+1){1'b0}}, v};
    endfunction

    function automatic logic [MW-1:0] mag(coord_t v);
        mag = v[VW-1] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic inside_f(clip_edge_t e, vertex_t p, coord_t b);
        unique case (e)
            EDGE_LEFT:   inside_f = $signed(p.x) > $signed(b);
            EDGE_RIGHT:  inside_f = $signed(p.x) < $signed(b);
            EDGE_BOTTOM: inside_f = $signed(p.y) > $signed(b);
            EDGE_TOP:    inside_f = $signed(p.y) < $signed(b);
            default:     inside_f = 1'b0;
        endcase
    endfunction

    state_t                 state_reg, state_next;
    clip_edge_t             edge_reg, edge_next;
    logic [IW-1:0]          rem_reg, rem_next;
    logic [IW-1:0]          m_reg, m_next;
    logic [1:0]             load_reg, load_next;
    logic                   done_reg, done_next;
    vertex_t                prev_reg, prev_next;
    coord_t                 bnd_reg [4];
    vertex_t                corner_reg [4];
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic [AREA_WIDTH-1:0]  area_reg, area_next;

    cell_ctrl_t             ctrl;
    vertex_t                cell_v [POLY_CAP];
    vertex_t                cur;
    vertex_t                last_v;
    coord_t                 bnd;
    logic                   clip_x;
    logic                   in1;
    logic                   in2;
    coord_t                 base;
    coord_t                 num;
    coord_t                 av;
    coord_t                 den;
    logic [MW-1:0]          nm;
    logic [MW-1:0]          dm;
    logic                   lerp_neg;
    logic [PW:0]            q_round;
    logic [MW-1:0]          q_clamp;
    coord_t                 res;
    vertex_t                isect;

    logic                   mul_start;
    logic [MW-1:0]          mul_a;
    logic [MW-1:0]          mul_b;
    logic                   mul_done;
    logic [PW-1:0]          mul_product;
    logic                   div_start;
    logic                   div_done;
    logic [PW-1:0]          div_quot;
    logic [MW-1:0]          div_rem;

    logic signed [ACCW-1:0] prod_ext;
    logic                   t1_neg;
    logic                   t2_neg;
    logic [ACCW-1:0]        acc_mag;
    logic [ACCW-1:0]        acc_round;
    logic [ACCW-4:0]        area_full;

    genvar gi;
    generate
        for (gi = 0; gi < POLY_CAP; gi++)
        begin : g_cell
            qrca_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .position (IW'(gi)),
                .neighbor (cell_v[(gi + 1) % POLY_CAP]),
                .vertex   (cell_v[gi])
            );
        end
    endgenerate

    qrca_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    qrca_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mul_product),
        .divisor   (dm),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign cur    = cell_v[0];
    assign last_v = cell_v[rem_reg - 1'b1];
    assign bnd    = bnd_reg[edge_reg];
    assign clip_x = (edge_reg == EDGE_LEFT) || (edge_reg == EDGE_RIGHT);
    assign in1    = inside_f(edge_reg, prev_reg, bnd);
    assign in2    = inside_f(edge_reg, cur, bnd);

    always_comb
    begin
        if (clip_x)
        begin
            base = prev_reg.y;
            num  = cur.y - prev_reg.y;
            av   = bnd - prev_reg.x;
            den  = cur.x - prev_reg.x;
        end
        else
        begin
            base = prev_reg.x;
            num  = cur.x - prev_reg.x;
            av   = bnd - prev_reg.y;
            den  = cur.y - prev_reg.y;
        end
        nm       = mag(num);
        dm       = mag(den);
        lerp_neg = num[VW-1] ^ av[VW-1] ^ den[VW-1];
        q_round  = {1'b0, div_quot} + (PW+1)'({div_rem, 1'b0} >= {1'b0, dm});
        q_clamp  = (q_round > (PW+1)'(nm)) ? nm : q_round[MW-1:0];
        if (dm == '0)
        begin
            res = base;
        end
        else
        begin
            res = lerp_neg ? base - coord_t'(q_clamp) : base + coord_t'(q_clamp);
        end
        isect.x = clip_x ? bnd : res;
        isect.y = clip_x ? res : bnd;
    end

    assign t1_neg    = prev_reg.x[VW-1] ^ cur.y[VW-1];
    assign t2_neg    = cur.x[VW-1] ^ prev_reg.y[VW-1];
    assign prod_ext  = {{(ACCW-PW){1'b0}}, mul_product};
    assign acc_mag   = acc_reg[ACCW-1] ? ACCW'(-acc_reg) : ACCW'(acc_reg);
    assign acc_round = acc_mag + ACCW'(4);
    assign area_full = acc_round[ACCW-1:3];

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = mag(av);
        mul_b     = nm;
        div_start = (state_reg == ST_ISECT_MUL) && mul_done;
        unique case (state_reg)
            ST_STEP:
            begin
                mul_start = in1 != in2;
                mul_a     = nm;
                mul_b     = mag(av);
            end
            ST_AREA_STEP:
            begin
                mul_start = 1'b1;
                mul_a     = mag(prev_reg.x);
                mul_b     = mag(cur.y);
            end
            ST_AREA_MUL1:
            begin
                mul_start = mul_done;
                mul_a     = mag(cur.x);
                mul_b     = mag(prev_reg.y);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        edge_next    = edge_reg;
        rem_next     = rem_reg;
        m_next       = m_reg;
        load_next    = load_reg;
        done_next    = 1'b0;
        prev_next    = prev_reg;
        acc_next     = acc_reg;
        area_next    = area_reg;
        ctrl.shift   = 1'b0;
        ctrl.wr_en   = 1'b0;
        ctrl.wr_idx  = rem_reg + m_reg;
        ctrl.wr_data = isect;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    load_next  = '0;
                    acc_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_idx  = IW'(load_reg);
                ctrl.wr_data = corner_reg[load_reg];
                load_next    = load_reg + 1'b1;
                if (load_reg == 2'd3)
                begin
                    rem_next   = IW'(4);
                    m_next     = '0;
                    edge_next  = EDGE_LEFT;
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    prev_next  = last_v;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = (in1 != in2) ? ST_ISECT_MUL : ST_POP;
            end
            ST_ISECT_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_ISECT_DIV;
                end
            end
            ST_ISECT_DIV:
            begin
                if (div_done)
                begin
                    ctrl.wr_en = 1'b1;
                    m_next     = m_reg + 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                ctrl.shift   = 1'b1;
                ctrl.wr_en   = in2;
                ctrl.wr_idx  = rem_reg - 1'b1 + m_reg;
                ctrl.wr_data = cur;
                prev_next    = cur;
                if (rem_reg == IW'(1))
                begin
                    rem_next = m_reg + IW'(in2);
                    m_next   = '0;
                    if (edge_reg == EDGE_TOP)
                    begin
                        state_next = ST_AREA_START;
                    end
                    else
                    begin
                        edge_next  = clip_edge_t'(edge_reg + 1'b1);
                        state_next = ST_PASS;
                    end
                end
                else
                begin
                    rem_next   = rem_reg - 1'b1;
                    m_next     = m_reg + IW'(in2);
                    state_next = ST_STEP;
                end
            end
            ST_AREA_START:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    prev_next  = last_v;
                    state_next = ST_AREA_STEP;
                end
            end
            ST_AREA_STEP:
            begin
                state_next = ST_AREA_MUL1;
            end
            ST_AREA_MUL1:
            begin
                if (mul_done)
                begin
                    acc_next   = t1_neg ? acc_reg - prod_ext : acc_reg + prod_ext;
                    state_next = ST_AREA_MUL2;
                end
            end
            ST_AREA_MUL2:
            begin
                if (mul_done)
                begin
                    acc_next   = t2_neg ? acc_reg + prod_ext : acc_reg - prod_ext;
                    ctrl.shift = 1'b1;
                    prev_next  = cur;
                    rem_next   = rem_reg - 1'b1;
                    state_next = (rem_reg == IW'(1)) ? ST_FINISH : ST_AREA_STEP;
                end
            end
            ST_FINISH:
            begin
                if (area_full > (ACCW-3)'({AREA_WIDTH{1'b1}}))
                begin
                    area_next = {AREA_WIDTH{1'b1}};
                end
                else
                begin
                    area_next = area_full[AREA_WIDTH-1:0];
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= EDGE_LEFT;
            rem_reg   <= '0;
            m_reg     <= '0;
            load_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            rem_reg   <= rem_next;
            m_reg     <= m_next;
            load_reg  <= load_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        acc_reg  <= acc_next;
        area_reg <= area_next;
        if (state_reg == ST_IDLE && start)
        begin
            bnd_reg[EDGE_LEFT]   <= ext_coord(cell_center_x) - ext_size(cell_width);
            bnd_reg[EDGE_RIGHT]  <= ext_coord(cell_center_x) + ext_size(cell_width);
            bnd_reg[EDGE_BOTTOM] <= ext_coord(cell_center_y) - ext_size(cell_height);
            bnd_reg[EDGE_TOP]    <= ext_coord(cell_center_y) + ext_size(cell_height);
            corner_reg[0].x      <= ext_coord(corner0_x);
            corner_reg[0].y      <= ext_coord(corner0_y);
            corner_reg[1].x      <= ext_coord(corner1_x);
            corner_reg[1].y      <= ext_coord(corner1_y);
            corner_reg[2].x      <= ext_coord(corner2_x);
            corner_reg[2].y      <= ext_coord(corner2_y);
            corner_reg[3].x      <= ext_coord(corner3_x);
            corner_reg[3].y      <= ext_coord(corner3_y);
        end
    end

    assign busy         = state_reg != ST_IDLE;
    assign done         = done_reg;
    assign overlap_area = area_reg;

endmodule
